>>> sv/b64e_pkg.sv
// Shared types, constants and the character map for the base64 stream encoder.
package b64e_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } b64e_req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } b64e_rsp_type;

   // one output slot: six-bit group index or a pad character
   typedef struct packed {
      logic       pad;
      logic [5:0] group;
   } b64e_sym_type;

   // all characters caused by one input byte
   typedef struct packed {
      b64e_sym_type [3:0] sym;
      logic [1:0]         last_idx;
      logic               eom;
   } b64e_job_type;

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } b64e_phase_type;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_LOWER = 8'h61;
   localparam logic [7:0] CHAR_DIGIT = 8'h30;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   function automatic logic [7:0] b64e_char(input logic [5:0] group);
      logic [7:0] g;
      logic [7:0] code;
      g = {2'b00, group};
      if (group < 6'd26) begin
         code = CHAR_UPPER + g;
      end else if (group < 6'd52) begin
         code = CHAR_LOWER + g - 8'd26;
      end else if (group < 6'd62) begin
         code = CHAR_DIGIT + g - 8'd52;
      end else if (group == 6'd62) begin
         code = CHAR_PLUS;
      end else begin
         code = CHAR_SLASH;
      end
      return code;
   endfunction

endpackage

>>> sv/b64e_front.sv
// Front end: accepts bytes, tracks leftover bits and splits each byte into output slots.
module b64e_front
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  b64e_req_type req_data,
   input  logic         job_full,
   output logic         job_push,
   output b64e_job_type job_data
);

   b64e_phase_type phase_ff, phase_in;
   logic [3:0]     spare_ff, spare_in;
   logic [7:0]     b;
   logic           eom;

   assign b        = req_data.data_byte;
   assign eom      = req_data.end_of_message;
   assign job_push = req_push && !job_full;

   always_comb begin
      job_data = '0;
      job_data.eom = eom;
      case (phase_ff)
         PHASE_1: begin
            job_data.sym[0].group = {spare_ff[1:0], b[7:4]};
            spare_in = b[3:0];
            phase_in = PHASE_2;
            if (eom) begin
               job_data.sym[1].group = {b[3:0], 2'b00};
               job_data.sym[2].pad   = 1'b1;
               job_data.last_idx     = 2'd2;
            end
         end
         PHASE_2: begin
            job_data.sym[0].group = {spare_ff, b[7:6]};
            job_data.sym[1].group = b[5:0];
            job_data.last_idx     = 2'd1;
            spare_in = '0;
            phase_in = PHASE_0;
         end
         default: begin
            job_data.sym[0].group = b[7:2];
            spare_in = {2'b00, b[1:0]};
            phase_in = PHASE_1;
            if (eom) begin
               job_data.sym[1].group = {b[1:0], 4'b0000};
               job_data.sym[2].pad   = 1'b1;
               job_data.sym[3].pad   = 1'b1;
               job_data.last_idx     = 2'd3;
            end
         end
      endcase
      if (eom) begin
         spare_in = '0;
         phase_in = PHASE_0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         spare_ff <= '0;
      end else if (job_push) begin
         phase_ff <= phase_in;
         spare_ff <= spare_in;
      end
   end

endmodule

>>> sv/b64e_fifo.sv
// Small job queue between the front end and the character emitter.
module b64e_fifo
   import b64e_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr,
   input  b64e_job_type wr_data,
   output logic         full,
   input  logic         rd,
   output b64e_job_type rd_data,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64e_job_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr && !full;
   assign do_rd   = rd && !empty;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/b64e_back.sv
// Back end: walks the slots of the head job and emits one character per cycle while the receiver pops.
module b64e_back
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  b64e_job_type job_data,
   output logic         job_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output b64e_rsp_type rsp_data
);

   logic [1:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   b64e_rsp_type out_ff, out_in;
   b64e_sym_type sym;
   logic         load;
   logic         at_last;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;
   assign sym       = job_data.sym[idx_ff];
   assign load      = job_valid && (!valid_ff || rsp_pop);
   assign at_last   = (idx_ff == job_data.last_idx);
   assign job_pop   = load && at_last;

   always_comb begin
      out_in.char_code = sym.pad ? CHAR_PAD : b64e_char(sym.group);
      out_in.last_char = job_data.eom && at_last;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> idx_ff <= job_data.last_idx)
      else $error("slot index past end of job");

   a_last_pops_job: assert property (@(posedge clock) disable iff (reset)
      (load && out_in.last_char) |-> job_pop)
      else $error("final character without retiring its job");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> !job_pop)
      else $error("job popped from empty queue");

   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> idx_ff == 2'd0)
      else $error("slot index not restarted after job");
`endif

endmodule

>>> sv/base64_byte_stream_encoder.sv
// Base64 stream encoder (standard alphabet, '=' padding): one raw byte in, its characters out.
// Each accepted byte is split into one to four output slots by the front end in the same cycle
// and stored in a job queue of JOB_DEPTH entries; the back end takes one slot per cycle from
// the head job into an output register while it is empty or popped. A byte is accepted in any
// cycle in which the job queue has room; its first character passes through the job queue and
// the output register to the result ports, which give one character per cycle while popped, so
// three bytes give four characters and a final byte two to four. last_char marks the final
// character of a message, after which the encoder is back in its start state.
module base64_byte_stream_encoder
   import b64e_pkg::*;
#(
   parameter int JOB_DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  b64e_req_type req_data,
   output logic         req_full,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output b64e_rsp_type rsp_data
);

   b64e_job_type push_job;
   b64e_job_type head_job;
   logic         push;
   logic         pop;
   logic         q_empty;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .job_full (req_full),
      .job_push (push),
      .job_data (push_job)
   );

   b64e_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (push),
      .wr_data (push_job),
      .full    (req_full),
      .rd      (pop),
      .rd_data (head_job),
      .empty   (q_empty)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job_data  (head_job),
      .job_pop   (pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/b64e_char_checker.sv
// Checker for the base64 stream encoder: predicts the characters of each byte and compares.
`timescale 1ns / 1ps

module b64e_char_checker
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  b64e_req_type req_data,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  b64e_rsp_type rsp_data,
   output int           error_count,
   output int           chars_checked,
   output int           due_count
);

   localparam logic [511:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   b64e_rsp_type   chars_due[$];
   b64e_rsp_type   oldest;
   logic [3:0]     held_bits;
   b64e_phase_type byte_phase;

   initial begin
      error_count   = 0;
      chars_checked = 0;
      due_count     = 0;
      held_bits     = '0;
      byte_phase    = PHASE_0;
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] g);
      return ALPHABET[8 * (63 - int'(g)) +: 8];
   endfunction

   task automatic queue_char(input logic [7:0] code);
      b64e_rsp_type c;
      c.char_code = code;
      c.last_char = 1'b0;
      chars_due = {chars_due, c};
   endtask

   task automatic encode_byte(input b64e_req_type t);
      logic [7:0]   b;
      b64e_rsp_type tail;
      b = t.data_byte;
      case (byte_phase)
         PHASE_1: begin
            queue_char(sextet_char({held_bits[1:0], b[7:4]}));
            held_bits  = b[3:0];
            byte_phase = PHASE_2;
            if (t.end_of_message) begin
               queue_char(sextet_char({b[3:0], 2'b00}));
               queue_char(CHAR_PAD);
            end
         end
         PHASE_2: begin
            queue_char(sextet_char({held_bits, b[7:6]}));
            queue_char(sextet_char(b[5:0]));
            held_bits  = '0;
            byte_phase = PHASE_0;
         end
         default: begin
            queue_char(sextet_char(b[7:2]));
            held_bits  = {2'b00, b[1:0]};
            byte_phase = PHASE_1;
            if (t.end_of_message) begin
               queue_char(sextet_char({b[1:0], 4'b0000}));
               queue_char(CHAR_PAD);
               queue_char(CHAR_PAD);
            end
         end
      endcase
      if (t.end_of_message) begin
         tail = chars_due.pop_back();
         tail.last_char = 1'b1;
         chars_due = {chars_due, tail};
         held_bits  = '0;
         byte_phase = PHASE_0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         chars_due.delete();
         held_bits  = '0;
         byte_phase = PHASE_0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (chars_due.size() == 0) begin
               $error("unexpected transaction: char_code %0h last_char %0b",
                      rsp_data.char_code, rsp_data.last_char);
               error_count++;
            end else begin
               oldest = chars_due.pop_front();
               if (rsp_data.char_code !== oldest.char_code) begin
                  $error("char_code: expected %0h, actual %0h",
                         oldest.char_code, rsp_data.char_code);
                  error_count++;
               end
               if (rsp_data.last_char !== oldest.last_char) begin
                  $error("last_char: expected %0b, actual %0b",
                         oldest.last_char, rsp_data.last_char);
                  error_count++;
               end
               chars_checked++;
            end
         end
         if (req_push && !req_full) begin
            encode_byte(req_data);
         end
      end
      due_count <= chars_due.size();
   end

endmodule

>>> tb/tb_base64_byte_stream_encoder.sv
// Testbench top for the base64 stream encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_base64_byte_stream_encoder;
   import b64e_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_push;
   b64e_req_type req_data;
   logic         req_full;
   logic         rsp_empty;
   logic         rsp_pop;
   b64e_rsp_type rsp_data;

   int error_count;
   int chars_checked;
   int due_count;
   int cycle_count = 0;
   int send_idle_pct;
   int pop_stall_pct;
   int bytes_sent = 0;
   int messages_sent = 0;

   base64_byte_stream_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   b64e_char_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .chars_checked (chars_checked),
      .due_count     (due_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_base64_byte_stream_encoder failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // push stays high across back-to-back transactions
   task automatic send_byte(input logic [7:0] b, input logic eom);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push                <= 1'b1;
      req_data.data_byte      <= b;
      req_data.end_of_message <= eom;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      if (eom) begin
         messages_sent++;
      end
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   task automatic send_random_until(input int target);
      int len;
      while (bytes_sent < target) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         send_message(len);
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      int         msg_len[$];
      int         k;

      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_data      <= '0;
      send_idle_pct = 25;
      pop_stall_pct = 75;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // lengths 1..6: all three padding cases, '+' and '/', all-zero and all-one bytes
      directed = '{8'h00, 8'hFF, 8'hF8, 8'hFC, 8'h00, 8'hFF, 8'h7E,
                   8'h4D, 8'h61, 8'h6E, 8'h3F, 8'hFB, 8'hEF, 8'hBE, 8'h01, 8'h80,
                   8'hAA, 8'h55, 8'hC3, 8'h3C, 8'h0F, 8'hF0};
      msg_len  = '{1, 1, 2, 3, 4, 5, 6};
      k = 0;
      foreach (msg_len[m]) begin
         for (int i = 0; i < msg_len[m]; i++) begin
            send_byte(directed[k], i == msg_len[m] - 1);
            k++;
         end
      end

      send_random_until(130);
      send_idle_pct = 75;
      pop_stall_pct = 25;
      send_random_until(240);
      send_idle_pct = 0;
      pop_stall_pct = 0;
      send_random_until(340);
      req_push <= 1'b0;

      do @(posedge clock); while (due_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d bytes in %0d messages encoded, %0d characters checked", bytes_sent,
               messages_sent, chars_checked);
      $display("idle mix: sender-light, receiver-light, then full rate");
      if (error_count == 0) begin
         $display("tb_base64_byte_stream_encoder passed");
      end else begin
         $display("tb_base64_byte_stream_encoder failed");
      end
      $finish;
   end

endmodule
